>>> design/srsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_pkg
// Shared types and constants for the stepper ramp step generator.
// ----------------------------------------------------------------------------
package srsg_pkg;

    localparam int unsigned RAMP_DEPTH = 256;
    localparam int unsigned RAMP_AW    = $clog2(RAMP_DEPTH);
    localparam int unsigned LAST_MAX   = RAMP_DEPTH - 1;

    localparam int unsigned CFG_AW = 4;
    localparam int unsigned CFG_DW = 32;

    localparam logic [15:0] FULL_SPEED_RESET = 16'd100;
    localparam logic [15:0] START_RESET      = 16'd1000;
    localparam logic [7:0]  LAST_INDEX_RESET = 8'd0;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_FULL_SPEED = 2'd0,
        REG_START      = 2'd1,
        REG_LAST_INDEX = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] cruise_period;
        logic [15:0] start_period;
        logic [7:0]  ramp_last_index;
    } cfg_t;

endpackage

>>> design/srsg_ramp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_ramp_mem
// Ramp period table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module srsg_ramp_mem
    import srsg_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [RAMP_AW-1:0] waddr,
    input  logic [15:0]        wdata,
    input  logic               re,
    input  logic [RAMP_AW-1:0] raddr,
    output logic [15:0]        rdata
);

    logic [15:0] mem [RAMP_DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/srsg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_cfg_regs
// APB-style configuration registers: full-speed period, start period and
// last ramp index.
// ----------------------------------------------------------------------------
module srsg_cfg_regs
    import srsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FULL_SPEED: cfg_next.cruise_period   = pwdata[15:0];
                REG_START:      cfg_next.start_period    = pwdata[15:0];
                REG_LAST_INDEX: cfg_next.ramp_last_index = pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FULL_SPEED: prdata = {16'd0, cfg_reg.cruise_period};
            REG_START:      prdata = {16'd0, cfg_reg.start_period};
            REG_LAST_INDEX: prdata = {24'd0, cfg_reg.ramp_last_index};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cruise_period   <= FULL_SPEED_RESET;
            cfg_reg.start_period    <= START_RESET;
            cfg_reg.ramp_last_index <= LAST_INDEX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/srsg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsg_core
// Input register, move state update and result register of the step
// generator, with the ramp table memory.
// ----------------------------------------------------------------------------
module srsg_core
    import srsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] step_count,
    input  logic        direction_in,
    input  logic [1:0]  motor_choice,
    input  logic [7:0]  ramp_index,
    input  logic [15:0] ramp_period,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        step_pulse,
    output logic        direction_out,
    output logic [1:0]  motor_select,
    output logic        busy_res,
    output logic [31:0] steps_left
);

    // Input stage.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    mode_t       s1_mode_reg;
    logic [31:0] s1_steps_reg;
    logic        s1_dir_reg;
    logic [1:0]  s1_motor_reg;
    logic [7:0]  s1_index_reg;
    logic [15:0] s1_period_reg;

    // Move state.
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] executed_reg, executed_next;
    logic [7:0]  decel_reg, decel_next;
    logic [15:0] period_reg, period_next;
    logic        from_ram_reg, from_ram_next;
    logic [15:0] tick_reg, tick_next;
    logic        moving_reg, moving_next;
    logic        dir_reg, dir_next;
    logic [1:0]  motor_reg, motor_next;

    // Result stage.
    logic        res_valid_reg, res_valid_next;
    logic        res_pulse_reg;
    logic        pulse;

    logic               advance;
    logic               proc;
    logic               ram_we;
    logic               ram_re;
    logic [RAMP_AW-1:0] ram_raddr;
    logic [RAMP_AW-1:0] ram_waddr;
    logic [15:0]        ram_rdata;
    logic [15:0]        period_eff;
    logic [16:0]        tick_inc;
    logic [31:0]        li_wide;
    logic [7:0]         li;
    logic [31:0]        idx_wide;
    logic [31:0]        half;
    logic [31:0]        rem_dec;
    logic [31:0]        rem_dec_m1;

    assign advance    = !res_valid_reg || !res_stall;
    assign item_stall = s1_valid_reg && !advance;
    assign proc       = s1_valid_reg && advance;

    assign s1_valid_next  = (!s1_valid_reg || advance) ? item_valid : s1_valid_reg;
    assign res_valid_next = advance ? s1_valid_reg : res_valid_reg;

    // The period after a ramp step sits in the read register of the memory
    // until the next step or start replaces it.
    assign period_eff = from_ram_reg ? ram_rdata : period_reg;
    assign tick_inc   = {1'b0, tick_reg} + 17'd1;
    assign li_wide    = 32'(cfg.ramp_last_index);
    assign li         = (li_wide > LAST_MAX) ? 8'(LAST_MAX) : cfg.ramp_last_index;
    assign idx_wide   = 32'(s1_index_reg);
    assign ram_waddr  = idx_wide[RAMP_AW-1:0];
    assign half       = s1_steps_reg >> 1;
    assign rem_dec    = remaining_reg - 32'd1;
    assign rem_dec_m1 = remaining_reg - 32'd2;

    always_comb
    begin
        remaining_next = remaining_reg;
        executed_next  = executed_reg;
        decel_next     = decel_reg;
        period_next    = period_reg;
        from_ram_next  = from_ram_reg;
        tick_next      = tick_reg;
        moving_next    = moving_reg;
        dir_next       = dir_reg;
        motor_next     = motor_reg;
        pulse          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        if (proc)
        begin
            case (s1_mode_reg)
                MODE_LOAD:
                begin
                    ram_we = (idx_wide < RAMP_DEPTH);
                end
                MODE_START:
                begin
                    executed_next  = '0;
                    remaining_next = s1_steps_reg;
                    decel_next     = (half > 32'(li)) ? li : half[7:0];
                    dir_next       = s1_dir_reg;
                    motor_next     = s1_motor_reg;
                    period_next    = cfg.start_period;
                    from_ram_next  = 1'b0;
                    tick_next      = '0;
                    moving_next    = (s1_steps_reg != 32'd0);
                end
                MODE_TICK:
                begin
                    if (moving_reg)
                    begin
                        if (tick_inc >= {1'b0, period_eff})
                        begin
                            pulse          = 1'b1;
                            tick_next      = '0;
                            remaining_next = rem_dec;
                            executed_next  = executed_reg + 32'd1;
                            if (rem_dec == 32'd0)
                            begin
                                moving_next = 1'b0;
                            end
                            else if (rem_dec <= 32'(decel_reg))
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = rem_dec_m1[RAMP_AW-1:0];
                                from_ram_next = 1'b1;
                            end
                            else if (executed_reg <= 32'(li))
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = executed_reg[RAMP_AW-1:0];
                                from_ram_next = 1'b1;
                            end
                            else
                            begin
                                period_next   = cfg.cruise_period;
                                from_ram_next = 1'b0;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc[15:0];
                        end
                    end
                end
                MODE_STOP:
                begin
                    moving_next = 1'b0;
                    tick_next   = '0;
                end
                default: ;
            endcase
        end
    end

    srsg_ramp_mem u_ramp_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s1_period_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            remaining_reg <= '0;
            executed_reg  <= '0;
            decel_reg     <= '0;
            period_reg    <= START_RESET;
            from_ram_reg  <= 1'b0;
            tick_reg      <= '0;
            moving_reg    <= 1'b0;
            dir_reg       <= 1'b0;
            motor_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            remaining_reg <= remaining_next;
            executed_reg  <= executed_next;
            decel_reg     <= decel_next;
            period_reg    <= period_next;
            from_ram_reg  <= from_ram_next;
            tick_reg      <= tick_next;
            moving_reg    <= moving_next;
            dir_reg       <= dir_next;
            motor_reg     <= motor_next;
        end
    end

    // Payload registers of the input word.
    always_ff @(posedge clk)
    begin
        if (!s1_valid_reg || advance)
        begin
            s1_mode_reg   <= mode_t'(mode);
            s1_steps_reg  <= step_count;
            s1_dir_reg    <= direction_in;
            s1_motor_reg  <= motor_choice;
            s1_index_reg  <= ramp_index;
            s1_period_reg <= ramp_period;
        end
    end

    // The result fields mirror the state left by the word just processed.
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            res_pulse_reg <= pulse;
        end
    end

    logic        res_dir_reg;
    logic [1:0]  res_motor_reg;
    logic        res_busy_reg;
    logic [31:0] res_steps_reg;

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            res_dir_reg   <= dir_next;
            res_motor_reg <= motor_next;
            res_busy_reg  <= moving_next;
            res_steps_reg <= remaining_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign step_pulse    = res_pulse_reg;
    assign direction_out = res_dir_reg;
    assign motor_select  = res_motor_reg;
    assign busy_res      = res_busy_reg;
    assign steps_left    = res_steps_reg;

`ifndef NO_ASSERTIONS
    a_moving_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (remaining_reg != 32'd0))
        else $error("move in progress with no steps left");

    a_idle_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !moving_reg |-> (tick_reg == 16'd0))
        else $error("tick counter not cleared while idle");

    a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ramp table read and written in the same cycle");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && res_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_pulse_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && pulse) |=> (remaining_reg == $past(remaining_reg) - 32'd1))
        else $error("step issued without decrementing the step count");
`endif

endmodule

>>> design/stepper_ramp_step_generator.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle unless res_stall holds a full result register;
// each word passes from the input register to the result register, the two
// stages of the pipeline, and the ramp table is read at a step for later ticks.
// Reset: rst_n clears the pipeline and the move state asynchronously; the
// period registers return to their defaults and the ramp table is not cleared.
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator
// Step pulse generator with a trapezoidal speed ramp and a loadable ramp table.
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator
    import srsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        mode,
    input  logic [31:0]       step_count,
    input  logic              direction_in,
    input  logic [1:0]        motor_choice,
    input  logic [7:0]        ramp_index,
    input  logic [15:0]       ramp_period,
    output logic              res_valid,
    input  logic              res_stall,
    output logic              step_pulse,
    output logic              direction_out,
    output logic [1:0]        motor_select,
    output logic              busy_res,
    output logic [31:0]       steps_left
);

    cfg_t cfg;

    srsg_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srsg_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .step_count    (step_count),
        .direction_in  (direction_in),
        .motor_choice  (motor_choice),
        .ramp_index    (ramp_index),
        .ramp_period   (ramp_period),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .step_pulse    (step_pulse),
        .direction_out (direction_out),
        .motor_select  (motor_select),
        .busy_res      (busy_res),
        .steps_left    (steps_left)
    );

endmodule

>>> bench/stepper_ramp_step_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator_test
// Self-checking bench for the ramp step generator. Words for loading the ramp
// table, starting, ticking and stopping moves are driven through the
// valid/stall input channel. A scoreboard keeps its own copy of the move state
// and the period registers, predicts one result per accepted word and checks
// every result field by field. Both channels idle at random, and the result
// side is once held off long enough to back the block up.
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator_test;
    import srsg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        mode_t       op;
        logic [31:0] steps;
        logic        dir;
        logic [1:0]  motor;
        logic [7:0]  idx;
        logic [15:0] period;
    } step_word_t;

    typedef struct packed {
        logic        pulse;
        logic        dir;
        logic [1:0]  motor;
        logic        busy;
        logic [31:0] left;
    } step_result_t;

    class step_scoreboard;
        logic [15:0]  ramp_tbl [RAMP_DEPTH];
        bit [31:0]    remaining;
        bit [31:0]    executed;
        bit [7:0]     decel;
        bit [15:0]    cur_period;
        bit [15:0]    ticks;
        bit           moving;
        bit           dir;
        bit [1:0]     motor;
        bit [15:0]    full_period;
        bit [15:0]    first_period;
        bit [7:0]     last_idx;
        step_result_t pending [$];
        int           errors;

        function new();
            full_period  = FULL_SPEED_RESET;
            first_period = START_RESET;
            last_idx     = LAST_INDEX_RESET;
            cur_period   = START_RESET;
            remaining    = '0;
            executed     = '0;
            decel        = '0;
            ticks        = '0;
            moving       = 1'b0;
            dir          = 1'b0;
            motor        = '0;
            errors       = 0;
        endfunction

        function void set_reg(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_FULL_SPEED: full_period  = v[15:0];
                REG_START:      first_period = v[15:0];
                REG_LAST_INDEX: last_idx     = v[7:0];
                default: ;
            endcase
        endfunction

        // Near the end of a move the table is walked backwards, near its start
        // forwards; in between the cruising period applies.
        function bit [15:0] following_period();
            if (remaining <= {24'd0, decel})
                return ramp_tbl[remaining[7:0] - 8'd1];
            if (executed <= {24'd0, last_idx})
                return ramp_tbl[executed[7:0]];
            return full_period;
        endfunction

        function void note_word(step_word_t w);
            step_result_t r;
            bit [16:0]    t;
            bit [31:0]    half;
            bit           pulse;
            pulse = 1'b0;
            case (w.op)
                MODE_LOAD: ramp_tbl[w.idx] = w.period;
                MODE_START:
                begin
                    half       = w.steps >> 1;
                    executed   = '0;
                    remaining  = w.steps;
                    decel      = (half > {24'd0, last_idx}) ? last_idx : half[7:0];
                    dir        = w.dir;
                    motor      = w.motor;
                    cur_period = first_period;
                    ticks      = '0;
                    moving     = (w.steps != 0);
                end
                MODE_TICK:
                begin
                    if (moving)
                    begin
                        t = {1'b0, ticks} + 17'd1;
                        if (t >= {1'b0, cur_period})
                        begin
                            pulse     = 1'b1;
                            ticks     = '0;
                            remaining = remaining - 1;
                            if (remaining == 0)
                                moving = 1'b0;
                            else
                                cur_period = following_period();
                            executed = executed + 1;
                        end
                        else
                        begin
                            ticks = t[15:0];
                        end
                    end
                end
                default:
                begin
                    moving = 1'b0;
                    ticks  = '0;
                end
            endcase
            r.pulse = pulse;
            r.dir   = dir;
            r.motor = motor;
            r.busy  = moving;
            r.left  = remaining;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(step_result_t got);
            step_result_t exp;
            if (pending.size() == 0)
            begin
                report("result word with no word outstanding");
                return;
            end
            exp = pending.pop_front();
            if (got.pulse !== exp.pulse)
                report($sformatf("step_pulse %0b, expected %0b", got.pulse, exp.pulse));
            if (got.dir !== exp.dir)
                report($sformatf("direction_out %0b, expected %0b", got.dir, exp.dir));
            if (got.motor !== exp.motor)
                report($sformatf("motor_select %0d, expected %0d", got.motor, exp.motor));
            if (got.busy !== exp.busy)
                report($sformatf("busy_res %0b, expected %0b", got.busy, exp.busy));
            if (got.left !== exp.left)
                report($sformatf("steps_left %0d, expected %0d", got.left, exp.left));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [1:0]        mode = '0;
    logic [31:0]       step_count = '0;
    logic              direction_in = 1'b0;
    logic [1:0]        motor_choice = '0;
    logic [7:0]        ramp_index = '0;
    logic [15:0]       ramp_period = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic              step_pulse;
    logic              direction_out;
    logic [1:0]        motor_select;
    logic              busy_res;
    logic [31:0]       steps_left;

    step_scoreboard sb = new();
    bit             calm = 1'b0;
    bit             hold_go = 1'b0;
    bit             loaded [RAMP_DEPTH];
    int             sent = 0;
    int             cycles = 0;

    stepper_ramp_step_generator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .step_count   (step_count),
        .direction_in (direction_in),
        .motor_choice (motor_choice),
        .ramp_index   (ramp_index),
        .ramp_period  (ramp_period),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .step_pulse   (step_pulse),
        .direction_out(direction_out),
        .motor_select (motor_select),
        .busy_res     (busy_res),
        .steps_left   (steps_left)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Accepted input words are noted before results are checked, so that the
    // ordering within one edge never matters.
    always @(posedge clk)
    begin
        step_word_t   w;
        step_result_t r;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                w.op     = mode_t'(mode);
                w.steps  = step_count;
                w.dir    = direction_in;
                w.motor  = motor_choice;
                w.idx    = ramp_index;
                w.period = ramp_period;
                sb.note_word(w);
            end
            if (res_valid && !res_stall)
            begin
                r.pulse = step_pulse;
                r.dir   = direction_out;
                r.motor = motor_select;
                r.busy  = busy_res;
                r.left  = steps_left;
                sb.check_result(r);
            end
        end
    end

    // Result side: random stalls, or one long hold-off when asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                res_stall <= 1'b1;
                repeat (79) @(posedge clk);
                hold_go = 1'b0;
            end
            else
            begin
                res_stall <= !calm && ($urandom_range(0, 99) < 16);
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic step_word_t make_word(mode_t op, logic [31:0] steps, logic dir,
                                             logic [1:0] motor, logic [7:0] idx,
                                             logic [15:0] period);
        step_word_t w;
        w.op     = op;
        w.steps  = steps;
        w.dir    = dir;
        w.motor  = motor;
        w.idx    = idx;
        w.period = period;
        return w;
    endfunction

    // Fields the mode does not use carry random values.
    function automatic step_word_t any_word(mode_t op);
        return make_word(op, $urandom, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endfunction

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'd0;
        if (r < 6)
            return 16'hFFFF;
        if (r < 10)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(1, 5));
    endfunction

    function automatic logic [31:0] pick_steps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'($urandom_range(0, 2));
        if (r < 16)
            return $urandom;
        return 32'($urandom_range(3, 40));
    endfunction

    task automatic send_word(input step_word_t w);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        mode         <= w.op;
        step_count   <= w.steps;
        direction_in <= w.dir;
        motor_choice <= w.motor;
        ramp_index   <= w.idx;
        ramp_period  <= w.period;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [15:0] period);
        step_word_t w;
        w = any_word(MODE_LOAD);
        w.idx    = idx;
        w.period = period;
        loaded[idx] = 1'b1;
        send_word(w);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
        @(posedge clk);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Every entry that a move may read under the new last index is written
    // before the first tick of the phase.
    task automatic set_phase(input logic [15:0] full, input logic [15:0] first,
                             input logic [7:0] last);
        settle();
        write_reg(REG_FULL_SPEED, {16'd0, full});
        write_reg(REG_START, {16'd0, first});
        write_reg(REG_LAST_INDEX, {24'd0, last});
        for (int i = 0; i <= last; i++)
            if (!loaded[i])
                load_entry(8'(i), 16'($urandom_range(1, 2)));
    endtask

    // Mostly whole moves with random content, the rest loads, stops and noise.
    task automatic random_words(input int count);
        step_word_t w;
        int         target;
        int         r;
        int         len;
        target = sent + count;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                w = any_word(MODE_START);
                w.steps = pick_steps();
                send_word(w);
                len = $urandom_range(4, 60);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 90)
                        send_word(any_word(MODE_TICK));
                    else if (r < 95)
                        load_entry(8'($urandom_range(0, 255)), pick_period());
                    else if (r < 97)
                        send_word(any_word(MODE_STOP));
                    else
                        send_word(any_word(mode_t'($urandom_range(0, 3))));
                end
            end
            else if (r < 85)
            begin
                load_entry(8'($urandom_range(0, 255)), pick_period());
            end
            else if (r < 93)
            begin
                send_word(any_word(mode_t'($urandom_range(0, 3))));
            end
            else
            begin
                send_word(any_word(MODE_STOP));
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] full, input logic [15:0] first,
                             input logic [7:0] last, input int count,
                             input bit quiet, input bit squeeze);
        set_phase(full, first, last);
        calm = quiet;
        if (squeeze)
            hold_go = 1'b1;
        random_words(count);
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: idle tick, idle stop, a zero-step start and
        // a longest move that is stopped with its step count kept.
        send_word(make_word(MODE_TICK, 32'd0, 1'b0, 2'd0, 8'd0, 16'd0));
        send_word(make_word(MODE_STOP, 32'd0, 1'b0, 2'd0, 8'd0, 16'd0));
        send_word(make_word(MODE_START, 32'd0, 1'b1, 2'd3, 8'd0, 16'd0));
        send_word(make_word(MODE_START, 32'hFFFF_FFFF, 1'b0, 2'd1, 8'hFF, 16'hFFFF));
        send_word(make_word(MODE_TICK, 32'd0, 1'b0, 2'd0, 8'd0, 16'd0));
        send_word(make_word(MODE_TICK, 32'hFFFF_FFFF, 1'b1, 2'd3, 8'hFF, 16'hFFFF));
        send_word(make_word(MODE_STOP, 32'd0, 1'b0, 2'd0, 8'd0, 16'd0));
        load_entry(8'hFF, 16'hFFFF);
        // A zero period in the table behaves as a period of one tick.
        load_entry(8'h00, 16'h0000);

        // A short move that accelerates, decelerates and ends on its last step.
        set_phase(16'd2, 16'd1, 8'd3);
        send_word(make_word(MODE_START, 32'd7, 1'b1, 2'd2, 8'd0, 16'd0));
        repeat (14) send_word(make_word(MODE_TICK, 32'd0, 1'b0, 2'd0, 8'd0, 16'd0));

        // The phase with the widest last index loads every ramp table entry not yet written.
        run_phase(16'd1, 16'd1, 8'd0, 60, 1'b0, 1'b0);
        run_phase(16'd4, 16'd6, 8'd7, 80, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'd3, 8'd255, 60, 1'b0, 1'b0);
        run_phase(16'd2, 16'd0, 8'd20, 100, 1'b0, 1'b1);
        run_phase(16'd5, 16'hFFFF, 8'd12, 20, 1'b0, 1'b0);
        run_phase(16'd1, 16'd2, 8'd4, 60, 1'b0, 1'b0);

        settle();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
design/srsg_pkg.sv
design/srsg_ramp_mem.sv
design/srsg_cfg_regs.sv
design/srsg_core.sv
design/stepper_ramp_step_generator.sv
bench/stepper_ramp_step_generator_test.sv
